[hw/rtl/hkrd_pkg.sv]
package hkrd_pkg;

  localparam int KEY_SLOTS = 6;

  localparam logic [7:0] KEY_NONE      = 8'h00;
  localparam logic [7:0] ROLLOVER_CODE = 8'h01;
  localparam logic [7:0] MOD_BASE      = 8'hE0;
  localparam logic [7:0] MARKER_CODE   = 8'h00;

  localparam int MOD_BITS = 8;

  // Event slots in emission order: modifier releases, modifier presses,
  // key releases, key presses, then the matrix-update marker.
  localparam int EV_MOD_REL = 0;
  localparam int EV_MOD_PRS = EV_MOD_REL + MOD_BITS;
  localparam int EV_KEY_REL = EV_MOD_PRS + MOD_BITS;
  localparam int EV_KEY_PRS = EV_KEY_REL + KEY_SLOTS;
  localparam int EV_MARKER  = EV_KEY_PRS + KEY_SLOTS;
  localparam int N_EV       = EV_MARKER + 1;

  localparam logic EVENT_KEY    = 1'b0;
  localparam logic EVENT_MARKER = 1'b1;

  typedef logic [KEY_SLOTS-1:0][7:0] key_list_t;

  typedef struct packed {
    logic [N_EV-1:0] mask;
    key_list_t       rel_codes;
    key_list_t       prs_codes;
  } job_t;

endpackage

[hw/rtl/hid_keyboard_report_differ.sv]
// A report's results go from the job register to the output register and out_valid.
// Throughput: one result per cycle while out_ready does not stall the output; a report gives
// its results (changed modifiers + released keys + pressed keys + 1 marker, at most 21) through the
// single result serialiser. The next report is taken in the cycle the last result of
// the previous one enters the output register; a rollover report is taken and dropped.
// Reset (rst_n low, synchronous) clears the stored report to all zero and empties the block.
module hid_keyboard_report_differ (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_modifier_bits,
  input  logic [7:0] in_reserved_byte,
  input  logic [7:0] in_key_slot_0,
  input  logic [7:0] in_key_slot_1,
  input  logic [7:0] in_key_slot_2,
  input  logic [7:0] in_key_slot_3,
  input  logic [7:0] in_key_slot_4,
  input  logic [7:0] in_key_slot_5,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_event_kind,
  output logic [7:0] out_scan_code,
  output logic       out_is_press,
  output logic       out_last_of_run
);
  import hkrd_pkg::*;

  logic [7:0]           prev_mods_r;
  key_list_t            prev_keys_r;
  key_list_t            cur_keys;
  logic [KEY_SLOTS-1:0] rel_live;
  logic [KEY_SLOTS-1:0] prs_live;
  logic [KEY_SLOTS-1:0] rel_fire;
  logic [KEY_SLOTS-1:0] prs_fire;
  logic                 rollover;
  logic                 take;
  logic                 job_load;
  logic                 job_ready;
  job_t                 job;
  logic                 rel_acc;
  logic                 prs_acc;

  assign cur_keys[0] = in_key_slot_0;
  assign cur_keys[1] = in_key_slot_1;
  assign cur_keys[2] = in_key_slot_2;
  assign cur_keys[3] = in_key_slot_3;
  assign cur_keys[4] = in_key_slot_4;
  assign cur_keys[5] = in_key_slot_5;

  assign rollover = (in_key_slot_0 == ROLLOVER_CODE);
  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;
  assign job_load = take && !rollover;

  // A slot takes part only if it and every slot before it are non-empty.
  always_comb begin
    rel_acc = 1'b1;
    prs_acc = 1'b1;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      rel_acc     = rel_acc && (prev_keys_r[i] != KEY_NONE);
      prs_acc     = prs_acc && (cur_keys[i] != KEY_NONE);
      rel_live[i] = rel_acc;
      prs_live[i] = prs_acc;
    end
  end

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    hkrd_lane u_rel (
      .code (prev_keys_r[i]),
      .list (cur_keys),
      .live (rel_live[i]),
      .fire (rel_fire[i])
    );
    hkrd_lane u_prs (
      .code (cur_keys[i]),
      .list (prev_keys_r),
      .live (prs_live[i]),
      .fire (prs_fire[i])
    );
  end

  hkrd_merge u_merge (
    .prev_mods (prev_mods_r),
    .cur_mods  (in_modifier_bits),
    .prev_keys (prev_keys_r),
    .cur_keys  (cur_keys),
    .rel_fire  (rel_fire),
    .prs_fire  (prs_fire),
    .job       (job)
  );

  hkrd_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_load        (job_load),
    .job_in          (job),
    .job_ready       (job_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_scan_code   (out_scan_code),
    .out_is_press    (out_is_press),
    .out_last_of_run (out_last_of_run)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mods_r <= '0;
      prev_keys_r <= '0;
    end else if (job_load) begin
      prev_mods_r <= in_modifier_bits;
      prev_keys_r <= cur_keys;
    end
  end

endmodule

[hw/rtl/hkrd_lane.sv]
module hkrd_lane (
  input  logic [7:0]         code,
  input  hkrd_pkg::key_list_t list,
  input  logic               live,
  output logic               fire
);
  import hkrd_pkg::*;

  logic found;
  logic scan_open;

  // The code counts as present only if it sits before the first empty slot.
  always_comb begin
    found     = 1'b0;
    scan_open = 1'b1;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (list[k] == KEY_NONE) begin
        scan_open = 1'b0;
      end
      if (scan_open && (list[k] == code)) begin
        found = 1'b1;
      end
    end
  end

  assign fire = live && !found;

endmodule

[hw/rtl/hkrd_merge.sv]
module hkrd_merge (
  input  logic [7:0]          prev_mods,
  input  logic [7:0]          cur_mods,
  input  hkrd_pkg::key_list_t prev_keys,
  input  hkrd_pkg::key_list_t cur_keys,
  input  logic [hkrd_pkg::KEY_SLOTS-1:0] rel_fire,
  input  logic [hkrd_pkg::KEY_SLOTS-1:0] prs_fire,
  output hkrd_pkg::job_t      job
);
  import hkrd_pkg::*;

  logic [MOD_BITS-1:0] mod_rel;
  logic [MOD_BITS-1:0] mod_prs;

  assign mod_rel = prev_mods & ~cur_mods;
  assign mod_prs = ~prev_mods & cur_mods;

  // The marker bit is always set, so every accepted report that is not a rollover yields a job.
  assign job.mask      = {1'b1, prs_fire, rel_fire, mod_prs, mod_rel};
  assign job.rel_codes = prev_keys;
  assign job.prs_codes = cur_keys;

endmodule

[hw/rtl/hkrd_serial.sv]
module hkrd_serial (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_load,
  input  hkrd_pkg::job_t job_in,
  output logic           job_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_event_kind,
  output logic [7:0]     out_scan_code,
  output logic           out_is_press,
  output logic           out_last_of_run
);
  import hkrd_pkg::*;

  logic [N_EV-1:0] mask_r, mask_nxt;
  key_list_t       rel_codes_r;
  key_list_t       prs_codes_r;
  logic            out_valid_r, out_valid_nxt;
  logic            kind_r;
  logic [7:0]      scan_r;
  logic            press_r;

  logic [N_EV-1:0] pick;
  logic [N_EV-1:0] rest;
  logic [7:0]      ev_code [N_EV];
  logic [7:0]      pick_code;
  logic            pick_press;
  logic            job_busy;
  logic            adv;

  assign job_busy = |mask_r;
  assign adv      = job_busy && (!out_valid_r || out_ready);
  assign pick     = mask_r & (~mask_r + {{(N_EV-1){1'b0}}, 1'b1});
  assign rest     = mask_r & ~pick;

  // The job register frees up in the cycle its last event moves out.
  assign job_ready = !job_busy || (adv && (rest == '0));

  always_comb begin
    for (int b = 0; b < MOD_BITS; b++) begin
      ev_code[EV_MOD_REL + b] = MOD_BASE + 8'(b);
      ev_code[EV_MOD_PRS + b] = MOD_BASE + 8'(b);
    end
    for (int k = 0; k < KEY_SLOTS; k++) begin
      ev_code[EV_KEY_REL + k] = rel_codes_r[k];
      ev_code[EV_KEY_PRS + k] = prs_codes_r[k];
    end
    ev_code[EV_MARKER] = MARKER_CODE;
  end

  always_comb begin
    pick_code = '0;
    for (int b = 0; b < N_EV; b++) begin
      if (pick[b]) begin
        pick_code = pick_code | ev_code[b];
      end
    end
  end

  assign pick_press = (|pick[EV_MOD_PRS +: MOD_BITS]) | (|pick[EV_KEY_PRS +: KEY_SLOTS]);

  always_comb begin
    mask_nxt = mask_r;
    if (job_load) begin
      mask_nxt = job_in.mask;
    end else if (adv) begin
      mask_nxt = rest;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      rel_codes_r <= job_in.rel_codes;
      prs_codes_r <= job_in.prs_codes;
    end
    if (adv) begin
      kind_r  <= pick[EV_MARKER] ? EVENT_MARKER : EVENT_KEY;
      scan_r  <= pick_code;
      press_r <= pick_press;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_scan_code   = scan_r;
  assign out_is_press    = press_r;
  assign out_last_of_run = kind_r;

endmodule

[hw/rtl/hkrd_checker.sv]
module hkrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_event_kind,
  input logic [7:0] out_scan_code,
  input logic       out_is_press,
  input logic       out_last_of_run
);
  import hkrd_pkg::*;

  // The output register is emptied by reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scan_code)
      && $stable(out_event_kind) && $stable(out_is_press))
    else $error("stalled result changed");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_run == out_event_kind))
    else $error("last flag not on the marker alone");

  a_marker_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EVENT_MARKER) |->
      (out_scan_code == MARKER_CODE) && !out_is_press)
    else $error("marker carries a key");

  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EVENT_KEY) |-> (out_scan_code != KEY_NONE))
    else $error("key event with empty code");

endmodule

bind hid_keyboard_report_differ hkrd_checker u_hkrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_kind  (out_event_kind),
  .out_scan_code   (out_scan_code),
  .out_is_press    (out_is_press),
  .out_last_of_run (out_last_of_run)
);

[tb/testbench.sv]
module testbench;
  import hkrd_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 215;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 100;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] mods;
    logic [7:0] rsvd;
    key_list_t  keys;
  } report_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic       press;
    logic       last;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_modifier_bits = '0;
  logic [7:0] in_reserved_byte = '0;
  logic [7:0] in_key_slot_0 = '0;
  logic [7:0] in_key_slot_1 = '0;
  logic [7:0] in_key_slot_2 = '0;
  logic [7:0] in_key_slot_3 = '0;
  logic [7:0] in_key_slot_4 = '0;
  logic [7:0] in_key_slot_5 = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_event_kind;
  logic [7:0] out_scan_code;
  logic       out_is_press;
  logic       out_last_of_run;

  hid_keyboard_report_differ uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_modifier_bits(in_modifier_bits),
    .in_reserved_byte(in_reserved_byte),
    .in_key_slot_0   (in_key_slot_0),
    .in_key_slot_1   (in_key_slot_1),
    .in_key_slot_2   (in_key_slot_2),
    .in_key_slot_3   (in_key_slot_3),
    .in_key_slot_4   (in_key_slot_4),
    .in_key_slot_5   (in_key_slot_5),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_scan_code   (out_scan_code),
    .out_is_press    (out_is_press),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  report_t    pending_reports[$];
  key_event_t expected_events[$];

  // Last accepted report as the block should hold it.
  logic [7:0] held_mods = '0;
  key_list_t  held_keys = '0;

  int mismatches = 0;
  int events_seen = 0;
  int quiet_cycles = 0;

  function automatic bit key_listed(key_list_t list, logic [7:0] code);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (list[i] == KEY_NONE) return 1'b0;
      if (list[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_events(report_t r);
    logic [7:0] released;
    logic [7:0] pressed;
    if (r.keys[0] == ROLLOVER_CODE) return;
    released = held_mods & ~r.mods;
    pressed  = ~held_mods & r.mods;
    for (int b = 0; b < MOD_BITS; b++)
      if (released[b])
        expected_events.push_back(key_event_t'{EVENT_KEY, MOD_BASE + 8'(b), 1'b0, 1'b0});
    for (int b = 0; b < MOD_BITS; b++)
      if (pressed[b])
        expected_events.push_back(key_event_t'{EVENT_KEY, MOD_BASE + 8'(b), 1'b1, 1'b0});
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_keys[i] == KEY_NONE) break;
      if (!key_listed(r.keys, held_keys[i]))
        expected_events.push_back(key_event_t'{EVENT_KEY, held_keys[i], 1'b0, 1'b0});
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (r.keys[i] == KEY_NONE) break;
      if (!key_listed(held_keys, r.keys[i]))
        expected_events.push_back(key_event_t'{EVENT_KEY, r.keys[i], 1'b1, 1'b0});
    end
    expected_events.push_back(key_event_t'{EVENT_MARKER, MARKER_CODE, 1'b0, 1'b1});
    held_mods = r.mods;
    held_keys = r.keys;
  endfunction

  function automatic void queue_report(logic [7:0] mods, logic [7:0] rsvd,
                                       logic [7:0] k0, logic [7:0] k1, logic [7:0] k2,
                                       logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
    report_t r;
    r.mods    = mods;
    r.rsvd    = rsvd;
    r.keys[0] = k0;
    r.keys[1] = k1;
    r.keys[2] = k2;
    r.keys[3] = k3;
    r.keys[4] = k4;
    r.keys[5] = k5;
    pending_reports.push_back(r);
  endfunction

  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // Driver: offers the queued reports with random gaps between transfers.
  report_t offered;
  int      gap_left = 0;
  bit      tx_calm = 1'b0;

  always @(posedge clk) begin
    logic nv;
    int   pick;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_events(offered);
        nv = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        pick = $urandom_range(0, 99);
        if (tx_calm || pick < 60) gap_left = 0;
        else if (pick < 90) gap_left = $urandom_range(1, 4);
        else gap_left = $urandom_range(10, 40);
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reports.size() > 0) begin
          offered = pending_reports.pop_front();
          in_modifier_bits <= offered.mods;
          in_reserved_byte <= offered.rsvd;
          in_key_slot_0    <= offered.keys[0];
          in_key_slot_1    <= offered.keys[1];
          in_key_slot_2    <= offered.keys[2];
          in_key_slot_3    <= offered.keys[3];
          in_key_slot_4    <= offered.keys[4];
          in_key_slot_5    <= offered.keys[5];
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // Monitor: checks each result transfer and throttles out_ready.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit rx_calm = 1'b0;

  always @(posedge clk) begin
    key_event_t want;
    int         pick;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          $error("result with nothing expected: kind %0d code %02h press %0d last %0d",
                 out_event_kind, out_scan_code, out_is_press, out_last_of_run);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (out_event_kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, out_event_kind);
            mismatches++;
          end
          if (out_scan_code !== want.code) begin
            $error("scan_code: expected %02h, got %02h", want.code, out_scan_code);
            mismatches++;
          end
          if (out_is_press !== want.press) begin
            $error("is_press: expected %0d, got %0d", want.press, out_is_press);
            mismatches++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
            mismatches++;
          end
        end
        if (events_seen % 50 == 0) rx_calm = !rx_calm;
        pick = $urandom_range(0, 99);
        if (rx_calm || pick < 65) stall_left = 0;
        else if (pick < 92) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(8, 40);
      end
      // One long hold-off so that the block backs up and stalls its input.
      if (!hold_done && events_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [7:0] mods_g;
    key_list_t  keys_g;
    int         n;
    int         kept;
    int         pick;
    mods_g = '0;
    kept = 0;

    // Directed reports.
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hFF, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA);
    // Every modifier and every key changes: the longest run of results.
    queue_report(8'h00, 8'h5A, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    // Rollover reports are dropped and leave the stored report alone.
    queue_report(8'hAA, 8'h00, ROLLOVER_CODE, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hFF, 8'hFF, ROLLOVER_CODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_report(8'h00, 8'hA5, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    // Code 1 outside the first slot is an ordinary key.
    queue_report(8'h01, 8'h00, 8'h04, ROLLOVER_CODE, 8'h06, 8'h00, 8'h00, 8'h00);
    queue_report(8'h80, 8'h00, ROLLOVER_CODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h80, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // A zero ends the list; the stored slots behind it never match.
    queue_report(8'h00, 8'h00, 8'h05, 8'h00, 8'h06, 8'h07, 8'h00, 8'h00);
    queue_report(8'h00, 8'h00, 8'h06, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h00, 8'h00, 8'h00, 8'h06, 8'h07, 8'h00, 8'h00, 8'h00);
    // Repeated codes give one event per entry.
    queue_report(8'h00, 8'h00, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h55, 8'h00, 8'h1E, 8'h1E, 8'h1E, 8'h1F, 8'h1F, 8'h1E);
    queue_report(8'hAA, 8'h00, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // Random part: mostly plausible keyboards over a small key pool so that
    // successive reports overlap, with some noise and rollover reports.
    while (kept < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_report(rand_byte(0, 255), rand_byte(0, 255), ROLLOVER_CODE,
                     rand_byte(0, 255), rand_byte(0, 255),
                     rand_byte(0, 255), rand_byte(0, 255),
                     rand_byte(0, 255));
      end else if (pick < 14) begin
        for (int i = 0; i < KEY_SLOTS; i++) keys_g[i] = rand_byte(0, 255);
        queue_report(rand_byte(0, 255), rand_byte(0, 255), keys_g[0],
                     keys_g[1], keys_g[2], keys_g[3], keys_g[4], keys_g[5]);
        if (keys_g[0] != ROLLOVER_CODE) kept++;
      end else begin
        if ($urandom_range(0, 1) == 1)
          mods_g = mods_g ^ (rand_byte(0, 255) & rand_byte(0, 255));
        n = $urandom_range(0, KEY_SLOTS);
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (i < n)
            keys_g[i] = ($urandom_range(0, 3) == 0) ? rand_byte(2, 255)
                                                    : rand_byte(4, 12);
          else if ($urandom_range(0, 7) == 0 && i > n)
            keys_g[i] = rand_byte(0, 255);
          else
            keys_g[i] = KEY_NONE;
        end
        queue_report(mods_g, rand_byte(0, 255), keys_g[0], keys_g[1], keys_g[2],
                     keys_g[3], keys_g[4], keys_g[5]);
        kept++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reports.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
